// ===== sv/isd_pkg.sv =====
// isd_pkg: payload types, register indexes and fixed widths of the stationarity detector
// no dependencies; every other file of the block but isd_ram refers to it by scoped names
`timescale 1ns / 1ps

package isd_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 24;
  localparam int TIME_W    = 48;
  localparam int LIMIT_W   = 23;
  localparam int WIDE_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int WLEN_W    = 7;
  localparam int ROOT_IN_W = 48;
  localparam int ROOT_W    = 24;

  // command codes
  localparam logic CMD_IMU = 1'b0;
  localparam logic CMD_GPS = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STD_LIM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STD_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_MEAN_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_AGE_LIM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GPS_SPEED_LIM  = 3'd5;

  typedef struct packed {
    logic                       command;
    logic [TIME_W-1:0]          time_us;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] vel_north;
    logic signed [SAMPLE_W-1:0] vel_east;
    logic [LIMIT_W-1:0]         vel_acc_north;
    logic [LIMIT_W-1:0]         vel_acc_east;
  } in_t;

  typedef struct packed {
    logic stationary;
    logic gps_recent;
  } out_t;

  // verdict of the merging stage
  typedef struct packed {
    logic full_ok;
    logic half_ok;
  } merge_res_t;

endpackage

// ===== sv/isd_ram.sv =====
// isd_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module isd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/isd_sqrt.sv =====
// isd_sqrt: floor square root, two radicand bits per cycle
// depends on isd_pkg for widths
`timescale 1ns / 1ps

module isd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [isd_pkg::ROOT_IN_W-1:0] radicand,
  output logic                          busy,
  output logic [isd_pkg::ROOT_W-1:0]    root
);

  localparam int RW = isd_pkg::ROOT_W + 2;
  localparam int CW = $clog2(isd_pkg::ROOT_W + 1);
  localparam logic [CW-1:0] LAST = CW'(isd_pkg::ROOT_W - 1);

  logic [isd_pkg::ROOT_IN_W-1:0] rad_r, rad_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [isd_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic [RW+1:0]                 rem_sh, trial;

  // one digit step
  always_comb begin
    rem_sh   = {rem_r, rad_r[isd_pkg::ROOT_IN_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt = rad_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = RW'(rem_sh - trial);
        root_nxt = {root_r[isd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = RW'(rem_sh);
        root_nxt = {root_r[isd_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LAST) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = run_r;
  assign root = root_r;

endmodule

// ===== sv/isd_lane.sv =====
// isd_lane: one ring channel with its memory, squarer and running sum and sum of squares
// depends on isd_pkg for widths and on isd_ram
`timescale 1ns / 1ps

module isd_lane #(
  parameter int WINDOW_CAP = 64,
  parameter bit IS_SIGNED  = 1'b1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [$clog2(WINDOW_CAP)-1:0]          wr_addr,
  input  logic [isd_pkg::SAMPLE_W-1:0]           wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(WINDOW_CAP)-1:0]          rd_addr,
  input  logic                                   acc_clr,
  output logic signed [isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1):0] sum,
  output logic [2*isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1)-1:0]   sumsq
);

  localparam int AW = $clog2(WINDOW_CAP + 1);
  localparam int DW = isd_pkg::SAMPLE_W + 1;
  localparam int SW = DW + AW;
  localparam int QW = 2 * isd_pkg::SAMPLE_W + AW;

  logic [isd_pkg::SAMPLE_W-1:0] rdata;
  logic signed [DW-1:0]         d_ext;
  logic signed [DW-1:0]         d_r;
  logic signed [2*DW-1:0]       sq_r;
  logic                         v1_r, v2_r;
  logic signed [SW-1:0]         sum_r, sum_nxt;
  logic [QW-1:0]                sumsq_r, sumsq_nxt;

  isd_ram #(
    .WIDTH(isd_pkg::SAMPLE_W),
    .DEPTH(WINDOW_CAP)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // sign or zero extension of the stored entry
  assign d_ext = {(IS_SIGNED ? rdata[isd_pkg::SAMPLE_W-1] : 1'b0), rdata};

  // running sums
  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    if (acc_clr) begin
      sum_nxt   = '0;
      sumsq_nxt = '0;
    end else if (v2_r) begin
      sum_nxt   = sum_r + SW'(d_r);
      sumsq_nxt = sumsq_r + QW'(sq_r[2*isd_pkg::SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
    end
    d_r     <= d_ext;
    sq_r    <= d_ext * d_ext;
    sum_r   <= sum_nxt;
    sumsq_r <= sumsq_nxt;
  end

  assign sum   = sum_r;
  assign sumsq = sumsq_r;

endmodule

// ===== sv/isd_merge.sv =====
// isd_merge: combines the lane sums into variance and mean terms and compares them to the limits
// depends on isd_pkg for widths and the verdict type
`timescale 1ns / 1ps

module isd_merge #(
  parameter int WINDOW_CAP = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [$clog2(WINDOW_CAP+1)-1:0]        w,
  input  logic signed [isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1):0] gx_sum,
  input  logic signed [isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1):0] gy_sum,
  input  logic signed [isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1):0] gz_sum,
  input  logic signed [isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1):0] a_sum,
  input  logic [2*isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1)-1:0]   gx_sq,
  input  logic [2*isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1)-1:0]   gy_sq,
  input  logic [2*isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1)-1:0]   gz_sq,
  input  logic [2*isd_pkg::SAMPLE_W+$clog2(WINDOW_CAP+1)-1:0]   a_sq,
  input  logic [isd_pkg::LIMIT_W-1:0]            gyro_std_lim,
  input  logic [isd_pkg::LIMIT_W-1:0]            accel_std_lim,
  input  logic [isd_pkg::LIMIT_W-1:0]            gyro_mean_lim,
  output logic                                   done,
  output isd_pkg::merge_res_t                    res
);

  localparam int AW  = $clog2(WINDOW_CAP + 1);
  localparam int SW  = isd_pkg::SAMPLE_W + 1 + AW;
  localparam int SXW = SW - 1;
  localparam int QW  = 2 * isd_pkg::SAMPLE_W + AW;
  localparam int PW  = 2 * SXW;
  localparam int CW  = PW + 4;

  // sequencer steps
  localparam logic [3:0] ST_GX    = 4'd0;
  localparam logic [3:0] ST_GY    = 4'd1;
  localparam logic [3:0] ST_GZ    = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_WLG   = 4'd4;
  localparam logic [3:0] ST_WLA   = 4'd5;
  localparam logic [3:0] ST_WLM   = 4'd6;
  localparam logic [3:0] ST_SQM   = 4'd7;
  localparam logic [3:0] ST_LASTM = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;

  logic [3:0]     step_r;
  logic           run_r, done_r;
  logic [SXW-1:0] mag_gx, mag_gy, mag_gz, mag_a;
  logic [QW-1:0]  mw_b;
  logic [SXW-1:0] sq_a;
  logic [PW-1:0]  mw_r, sq_r;
  logic [CW-1:0]  gvar_r, gmean_r, avar_r, gl_r, al_r, ml_r;
  logic [CW-1:0]  gvar_nxt, gmean_nxt, avar_nxt, gl_nxt, al_nxt, ml_nxt;
  isd_pkg::merge_res_t res_r;

  function automatic logic [SXW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] a;
    a = v[SW-1] ? SW'(-v) : SW'(v);
    return a[SXW-1:0];
  endfunction

  assign mag_gx = mag(gx_sum);
  assign mag_gy = mag(gy_sum);
  assign mag_gz = mag(gz_sum);
  assign mag_a  = mag(a_sum);

  // operand selection for the two multipliers
  always_comb begin
    mw_b = '0;
    sq_a = '0;
    case (step_r)
      ST_GX:  begin mw_b = gx_sq; sq_a = mag_gx; end
      ST_GY:  begin mw_b = gy_sq; sq_a = mag_gy; end
      ST_GZ:  begin mw_b = gz_sq; sq_a = mag_gz; end
      ST_ACC: begin mw_b = a_sq;  sq_a = mag_a;  end
      ST_WLG: begin mw_b = QW'(gyro_std_lim); end
      ST_WLA: begin mw_b = QW'(accel_std_lim); sq_a = mw_r[SXW-1:0]; end
      ST_WLM: begin mw_b = QW'(gyro_mean_lim); sq_a = mw_r[SXW-1:0]; end
      ST_SQM: begin sq_a = mw_r[SXW-1:0]; end
      default: ;
    endcase
  end

  // accumulate what the previous step multiplied
  always_comb begin
    gvar_nxt  = gvar_r;
    gmean_nxt = gmean_r;
    avar_nxt  = avar_r;
    gl_nxt    = gl_r;
    al_nxt    = al_r;
    ml_nxt    = ml_r;
    if (start) begin
      gvar_nxt  = '0;
      gmean_nxt = '0;
    end else if (run_r) begin
      case (step_r)
        ST_GY, ST_GZ, ST_ACC: begin
          gvar_nxt  = gvar_r + CW'(mw_r) - CW'(sq_r);
          gmean_nxt = gmean_r + CW'(sq_r);
        end
        ST_WLG:   avar_nxt = CW'(mw_r) - CW'(sq_r);
        ST_WLM:   gl_nxt   = CW'(sq_r) + (CW'(sq_r) << 1);
        ST_SQM:   al_nxt   = CW'(sq_r);
        ST_LASTM: ml_nxt   = CW'(sq_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= ST_GX;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= ST_GX;
      end else if (run_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == ST_CMP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    mw_r    <= PW'(w) * PW'(mw_b);
    sq_r    <= PW'(sq_a) * PW'(sq_a);
    gvar_r  <= gvar_nxt;
    gmean_r <= gmean_nxt;
    avar_r  <= avar_nxt;
    gl_r    <= gl_nxt;
    al_r    <= al_nxt;
    ml_r    <= ml_nxt;
    // limit compares, plain and with halved limits
    if (run_r && step_r == ST_CMP) begin
      res_r.full_ok <= (gvar_r < gl_r) && (avar_r < al_r) && (gmean_r < ml_r);
      res_r.half_ok <= ((gvar_r << 2) < gl_r) && ((avar_r << 2) < al_r) &&
                       ((gmean_r << 2) < ml_r);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== sv/imu_stationarity_detector.sv =====
// imu_stationarity_detector: top level with config registers, sequencer, four ring lanes
// depends on isd_pkg, isd_sqrt, isd_lane, isd_merge
// GPS report: squares the two velocities and takes the square root; no result is put out.
// IMU sample: squares and root, then, when the window is full, a scan of one entry per
// cycle through the four lanes and the merging sequence; otherwise straight to the output.
// One item at a time; the next is taken while a result still waits in the output register.
// Reset: synchronous; a clearing pass writes zero to every ring entry, no input taken.
`timescale 1ns / 1ps

module imu_stationarity_detector #(
  parameter int WINDOW_CAP = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  isd_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output isd_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [isd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isd_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(WINDOW_CAP + 1);
  localparam int IW = $clog2(WINDOW_CAP);
  localparam int SW = isd_pkg::SAMPLE_W + 1 + AW;
  localparam int QW = 2 * isd_pkg::SAMPLE_W + AW;
  localparam int MCW = $clog2(AW + 1);
  localparam logic [IW-1:0]  CLR_LAST = IW'(WINDOW_CAP - 1);
  localparam logic [15:0]    CAP16    = 16'(WINDOW_CAP);
  localparam logic [MCW-1:0] MOD_LAST = MCW'(AW);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SQ0   = 4'd2;
  localparam logic [3:0] S_SQ1   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_MERGE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // configuration registers
  logic [isd_pkg::WLEN_W-1:0]  wlen_r;
  logic [isd_pkg::LIMIT_W-1:0] gstd_r, astd_r, gmean_r;
  logic [isd_pkg::WIDE_W-1:0]  age_r, gspd_r;

  // block state
  logic [3:0]               state_r;
  isd_pkg::in_t             item_r;
  logic [IW-1:0]            head_r, clr_r;
  logic [AW-1:0]            fill_r, scan_r;
  logic [1:0]               drain_r;
  logic [isd_pkg::TIME_W-1:0]  rtime_r;
  logic                        rseen_r;
  logic [isd_pkg::ROOT_W-1:0]  rspeed_r;
  logic [isd_pkg::LIMIT_W-1:0] racc_r;
  logic                     recent_r, still_r;
  logic signed [2*isd_pkg::SAMPLE_W-1:0] sqa_r, sqb_r;
  logic                     out_valid_r;
  isd_pkg::out_t            out_r;

  // head modulo unit
  logic [AW-1:0]  mnum_r, mrem_r;
  logic [MCW-1:0] mcnt_r;
  logic [AW:0]    mrem_sh;

  logic [15:0]   wl16;
  logic [AW-1:0] w_cur;
  logic          accept, sqrt_start, sqrt_busy, root_done, imu_write, full_now;
  logic [isd_pkg::ROOT_W-1:0] root;
  logic [AW:0]   fill_inc;
  logic signed [isd_pkg::TIME_W:0] age_diff;
  logic          recent_now;
  logic [isd_pkg::WIDE_W-1:0] veto_lim;
  logic          merge_start, merge_done;
  isd_pkg::merge_res_t mres;
  logic          lane_we, lane_re, acc_clr;
  logic [IW-1:0] lane_waddr, lane_raddr;
  logic [isd_pkg::SAMPLE_W-1:0] wd_gx, wd_gy, wd_gz, wd_a;
  logic signed [SW-1:0] gx_sum, gy_sum, gz_sum, a_sum;
  logic [QW-1:0] gx_sq, gy_sq, gz_sq, a_sq;
  logic          still_now;

  // window length clamped to between 2 and the ring size
  assign wl16  = {{(16 - isd_pkg::WLEN_W){1'b0}}, wlen_r};
  assign w_cur = (wl16 < 16'd2) ? AW'(2) : ((wl16 > CAP16) ? AW'(WINDOW_CAP) : AW'(wl16));

  assign accept     = in_valid && in_ready;
  assign sqrt_start = (state_r == S_SQ1);
  assign root_done  = (state_r == S_ROOT) && !sqrt_busy && (mcnt_r == MOD_LAST);
  assign imu_write  = root_done && (item_r.command == isd_pkg::CMD_IMU);
  assign fill_inc   = {1'b0, fill_r} + (AW + 1)'(1);
  assign full_now   = !(fill_inc < {1'b0, w_cur});

  // report age, signed difference
  assign age_diff   = $signed({1'b0, in_data.time_us}) - $signed({1'b0, rtime_r});
  assign recent_now = rseen_r && (age_diff < $signed((isd_pkg::TIME_W + 1)'(age_r)));

  // veto threshold max(speed limit, 2 * accuracy)
  always_comb begin
    veto_lim = {racc_r, 1'b0};
    if (gspd_r > veto_lim) begin
      veto_lim = gspd_r;
    end
  end

  assign still_now = mres.full_ok &&
                     (recent_r ? !(rspeed_r > veto_lim) : mres.half_ok);

  // lane write and read control
  assign lane_we    = (state_r == S_CLEAR) || imu_write;
  assign lane_waddr = (state_r == S_CLEAR) ? clr_r : head_r;
  assign wd_gx      = (state_r == S_CLEAR) ? '0 : item_r.gyro_x;
  assign wd_gy      = (state_r == S_CLEAR) ? '0 : item_r.gyro_y;
  assign wd_gz      = (state_r == S_CLEAR) ? '0 : item_r.gyro_z;
  assign wd_a       = (state_r == S_CLEAR) ? '0 : root;
  assign lane_re    = (state_r == S_SCAN);
  assign lane_raddr = scan_r[IW-1:0];
  assign acc_clr    = imu_write;
  assign merge_start = (state_r == S_DRAIN) && (drain_r == 2'd2);

  assign mrem_sh = {mrem_r, mnum_r[AW-1]};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= 7'd32;
      gstd_r  <= 23'd655;
      astd_r  <= 23'd410;
      gmean_r <= 23'd1310;
      age_r   <= 24'd500000;
      gspd_r  <= 24'd410;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isd_pkg::REG_WINDOW_LENGTH: wlen_r  <= cfg_wdata[isd_pkg::WLEN_W-1:0];
        isd_pkg::REG_GYRO_STD_LIM:  gstd_r  <= cfg_wdata[isd_pkg::LIMIT_W-1:0];
        isd_pkg::REG_ACCEL_STD_LIM: astd_r  <= cfg_wdata[isd_pkg::LIMIT_W-1:0];
        isd_pkg::REG_GYRO_MEAN_LIM: gmean_r <= cfg_wdata[isd_pkg::LIMIT_W-1:0];
        isd_pkg::REG_VEL_AGE_LIM:   age_r   <= cfg_wdata;
        isd_pkg::REG_GPS_SPEED_LIM: gspd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      rseen_r     <= 1'b0;
      rtime_r     <= '0;
      rspeed_r    <= '0;
      racc_r      <= '0;
      out_valid_r <= 1'b0;
      mcnt_r      <= MOD_LAST;
      scan_r      <= '0;
      drain_r     <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // remainder of head + 1 by the window length, one bit a cycle
      if (sqrt_start) begin
        mnum_r <= AW'(head_r) + AW'(1);
        mrem_r <= '0;
        mcnt_r <= '0;
      end else if (mcnt_r != MOD_LAST) begin
        mnum_r <= mnum_r << 1;
        mrem_r <= (mrem_sh >= {1'b0, w_cur}) ? AW'(mrem_sh - {1'b0, w_cur}) : AW'(mrem_sh);
        mcnt_r <= mcnt_r + MCW'(1);
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_r   <= in_data;
            recent_r <= recent_now;
            if (in_data.command == isd_pkg::CMD_GPS) begin
              rseen_r <= 1'b1;
              rtime_r <= in_data.time_us;
              racc_r  <= (in_data.vel_acc_north > in_data.vel_acc_east) ?
                         in_data.vel_acc_north : in_data.vel_acc_east;
            end
            state_r <= S_SQ0;
          end
        end
        S_SQ0: begin
          if (item_r.command == isd_pkg::CMD_GPS) begin
            sqa_r <= item_r.vel_north * item_r.vel_north;
            sqb_r <= item_r.vel_east * item_r.vel_east;
          end else begin
            sqa_r <= item_r.accel_x * item_r.accel_x;
            sqb_r <= item_r.accel_y * item_r.accel_y;
          end
          state_r <= S_SQ1;
        end
        S_SQ1: state_r <= S_ROOT;
        S_ROOT: begin
          if (root_done) begin
            if (item_r.command == isd_pkg::CMD_GPS) begin
              rspeed_r <= root;
              state_r  <= S_IDLE;
            end else begin
              head_r <= mrem_r[IW-1:0];
              fill_r <= full_now ? w_cur : fill_inc[AW-1:0];
              scan_r <= '0;
              still_r <= 1'b0;
              state_r <= full_now ? S_SCAN : S_OUT;
            end
          end
        end
        S_SCAN: begin
          scan_r <= scan_r + AW'(1);
          if (scan_r == w_cur - AW'(1)) begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 2'd1;
          if (merge_start) begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_done) begin
            still_r <= still_now;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.stationary <= still_r;
            out_r.gps_recent <= recent_r;
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  isd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand(isd_pkg::ROOT_IN_W'(unsigned'(sqa_r)) + isd_pkg::ROOT_IN_W'(unsigned'(sqb_r))),
    .busy    (sqrt_busy),
    .root    (root)
  );

  isd_lane #(.WINDOW_CAP(WINDOW_CAP), .IS_SIGNED(1'b1)) u_lane_gx (
    .clk(clk), .rst_n(rst_n), .wr_en(lane_we), .wr_addr(lane_waddr), .wr_data(wd_gx),
    .rd_en(lane_re), .rd_addr(lane_raddr), .acc_clr(acc_clr), .sum(gx_sum), .sumsq(gx_sq)
  );

  isd_lane #(.WINDOW_CAP(WINDOW_CAP), .IS_SIGNED(1'b1)) u_lane_gy (
    .clk(clk), .rst_n(rst_n), .wr_en(lane_we), .wr_addr(lane_waddr), .wr_data(wd_gy),
    .rd_en(lane_re), .rd_addr(lane_raddr), .acc_clr(acc_clr), .sum(gy_sum), .sumsq(gy_sq)
  );

  isd_lane #(.WINDOW_CAP(WINDOW_CAP), .IS_SIGNED(1'b1)) u_lane_gz (
    .clk(clk), .rst_n(rst_n), .wr_en(lane_we), .wr_addr(lane_waddr), .wr_data(wd_gz),
    .rd_en(lane_re), .rd_addr(lane_raddr), .acc_clr(acc_clr), .sum(gz_sum), .sumsq(gz_sq)
  );

  isd_lane #(.WINDOW_CAP(WINDOW_CAP), .IS_SIGNED(1'b0)) u_lane_a (
    .clk(clk), .rst_n(rst_n), .wr_en(lane_we), .wr_addr(lane_waddr), .wr_data(wd_a),
    .rd_en(lane_re), .rd_addr(lane_raddr), .acc_clr(acc_clr), .sum(a_sum), .sumsq(a_sq)
  );

  isd_merge #(.WINDOW_CAP(WINDOW_CAP)) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (merge_start),
    .w            (w_cur),
    .gx_sum       (gx_sum),
    .gy_sum       (gy_sum),
    .gz_sum       (gz_sum),
    .a_sum        (a_sum),
    .gx_sq        (gx_sq),
    .gy_sq        (gy_sq),
    .gz_sq        (gz_sq),
    .a_sq         (a_sq),
    .gyro_std_lim (gstd_r),
    .accel_std_lim(astd_r),
    .gyro_mean_lim(gmean_r),
    .done         (merge_done),
    .res          (mres)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/isd_chk.sv =====
// isd_chk: port-level checks of the stationarity detector, bound to the top level
// depends on isd_pkg for the payload types
`timescale 1ns / 1ps

module isd_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input isd_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input isd_pkg::out_t                 out_data,
  input logic                          cfg_we,
  input logic [isd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [isd_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // the clearing pass after reset takes no input
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

endmodule

bind imu_stationarity_detector isd_chk u_isd_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .cfg_we   (cfg_we),
  .cfg_index(cfg_index),
  .cfg_wdata(cfg_wdata)
);
